// File: hw/rtl/vrpi_pkg.sv
// vrpi_pkg: constants, types and the arctangent table for the pose integrator
// used by velocity_ramp_pose_integrator; no other dependencies
package vrpi_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int PosWidthDefault    = 32;
    localparam int AtanCount          = 24;

    localparam logic [15:0] StepTimeReset = 16'd655;
    localparam logic [15:0] TimeoutReset  = 16'd50;
    localparam logic [14:0] AccelReset    = 15'd4096;
    localparam logic [14:0] DecelReset    = 15'd8192;

    localparam logic signed [31:0] CordicGain = 32'sd652032874;
    localparam logic [29:0]        RadToBam   = 30'd683565276;

    // register indexes
    localparam logic [2:0] RegStepTime  = 3'd0;
    localparam logic [2:0] RegTimeout   = 3'd1;
    localparam logic [2:0] RegAccelLin  = 3'd2;
    localparam logic [2:0] RegAccelAng  = 3'd3;
    localparam logic [2:0] RegDecelLin  = 3'd4;
    localparam logic [2:0] RegDecelAng  = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DLIN,
        ST_DANG,
        ST_SLEW,
        ST_HMUL0,
        ST_HMUL1,
        ST_HEAD,
        ST_CORDIC,
        ST_DIST,
        ST_PX,
        ST_PY,
        ST_DONE
    } state_t;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/velocity_ramp_pose_integrator.sv
// velocity_ramp_pose_integrator: slew-limited unicycle odometry, one tick per transaction
// depends on vrpi_pkg; one shared multiplier and a CORDIC stage under a sequencer
//
//  channel   direction  signals
//  s_        in         s_valid/s_ready, command_valid, targets, collision
//  m_        out        m_valid/m_ready, pose, velocities, flags
//  cfg       in         cfg_we, cfg_index, cfg_data
//
// one tick runs the CORDIC iterations and seven passes through the shared multiplier
// between accept and result.
// a new tick is taken once the result register is empty.
// synchronous active-low reset loads x and y with 10.0, zeroes the heading and clears all velocities.
// m_ready low holds the result and s_ready low.
module velocity_ramp_pose_integrator #(
    parameter int CORDIC_STEPS = vrpi_pkg::CordicStepsDefault,
    parameter int POS_WIDTH    = vrpi_pkg::PosWidthDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command_valid,
    input  logic signed [15:0] s_target_linear,
    input  logic signed [15:0] s_target_angular,
    input  logic               s_collision,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [15:0]        m_heading,
    output logic signed [15:0] m_vel_linear,
    output logic signed [15:0] m_vel_angular,
    output logic               m_emergency,
    output logic               m_stopped_by_collision
);
    import vrpi_pkg::*;

    localparam int Steps = (CORDIC_STEPS < AtanCount) ? CORDIC_STEPS : AtanCount;

    // configuration
    logic [15:0] step_time_reg, timeout_reg;
    logic [14:0] acc_lin_reg, acc_ang_reg, dec_lin_reg, dec_ang_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg <= StepTimeReset;
            timeout_reg   <= TimeoutReset;
            acc_lin_reg   <= AccelReset;
            acc_ang_reg   <= AccelReset;
            dec_lin_reg   <= DecelReset;
            dec_ang_reg   <= DecelReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegStepTime: step_time_reg <= cfg_data;
                RegTimeout:  timeout_reg   <= cfg_data;
                RegAccelLin: acc_lin_reg   <= cfg_data[14:0];
                RegAccelAng: acc_ang_reg   <= cfg_data[14:0];
                RegDecelLin: dec_lin_reg   <= cfg_data[14:0];
                RegDecelAng: dec_ang_reg   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // state
    state_t state_reg, state_next;
    logic signed [POS_WIDTH-1:0] x_reg, y_reg;
    logic [15:0] theta_reg, ticks_reg;
    logic signed [15:0] lin_reg, ang_reg, goal_lin_reg, goal_ang_reg;
    logic emerg_reg, hit_reg;
    logic [15:0] dlin_reg, dang_reg;
    logic signed [47:0] prod_reg;
    logic signed [31:0] hmul_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [4:0] iter_reg;
    logic [1:0] quad_reg;
    logic signed [31:0] dist_reg;
    logic signed [31:0] cos_v, sin_v;
    logic out_full_reg;

    // shared signed multiplier, 33 x 33 bits at most
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DLIN: begin
                mul_a = {18'd0, (emerg_reg ? dec_lin_reg : acc_lin_reg)};
                mul_b = {17'd0, step_time_reg};
            end
            ST_DANG: begin
                mul_a = {18'd0, (emerg_reg ? dec_ang_reg : acc_ang_reg)};
                mul_b = {17'd0, step_time_reg};
            end
            ST_HMUL0: begin
                mul_a = 33'(ang_reg);
                mul_b = {17'd0, step_time_reg};
            end
            ST_HMUL1: begin
                mul_a = 33'(hmul_reg);
                mul_b = {3'd0, RadToBam};
            end
            ST_DIST: begin
                mul_a = 33'(lin_reg);
                mul_b = {17'd0, step_time_reg};
            end
            ST_PX: begin
                mul_a = 33'(dist_reg);
                mul_b = 33'(cos_v);
            end
            ST_PY: begin
                mul_a = 33'(dist_reg);
                mul_b = 33'(sin_v);
            end
            default: ;
        endcase
    end

    // rounding right shift, half away from zero
    function automatic logic signed [65:0] rnd(input logic signed [65:0] v, input int s);
        logic [65:0] m;
        m = v[65] ? 66'(-v) : 66'(v);
        m = (m + (66'd1 << (s - 1))) >> s;
        return v[65] ? -$signed(m) : $signed(m);
    endfunction

    // slew toward a target without overshoot
    function automatic logic signed [15:0] slew(input logic signed [15:0] v,
                                                input logic signed [15:0] t,
                                                input logic [15:0] d);
        logic signed [17:0] n;
        logic signed [15:0] r;
        r = v;
        if (v < t) begin
            n = 18'(v) + $signed({2'b0, d});
            r = (n < 18'(t)) ? n[15:0] : t;
        end else if (v > t) begin
            n = 18'(v) - $signed({2'b0, d});
            r = (n > 18'(t)) ? n[15:0] : t;
        end
        return r;
    endfunction

    // saturating position add
    localparam logic signed [POS_WIDTH:0] PosHi = (POS_WIDTH+1)'((64'sd1 <<< (POS_WIDTH-1)) - 1);
    localparam logic signed [POS_WIDTH:0] PosLo = -PosHi - 1;
    function automatic logic signed [POS_WIDTH-1:0] padd(input logic signed [POS_WIDTH-1:0] p,
                                                         input logic signed [65:0] d);
        logic signed [67:0] n;
        n = 68'(p) + 68'(d);
        if (n > 68'(PosHi)) return PosHi[POS_WIDTH-1:0];
        if (n < 68'(PosLo)) return PosLo[POS_WIDTH-1:0];
        return n[POS_WIDTH-1:0];
    endfunction

    // quadrant restore
    always_comb begin
        unique case (quad_reg)
            2'd0: begin cos_v = cx_reg;  sin_v = cy_reg;  end
            2'd1: begin cos_v = -cy_reg; sin_v = cx_reg;  end
            2'd2: begin cos_v = -cx_reg; sin_v = -cy_reg; end
            default: begin cos_v = cy_reg; sin_v = -cx_reg; end
        endcase
    end

    logic s_fire, m_fire;
    assign s_ready = (state_reg == ST_IDLE) && !out_full_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_DLIN;
            ST_DLIN:   state_next = ST_DANG;
            ST_DANG:   state_next = ST_SLEW;
            ST_SLEW:   state_next = ST_HMUL0;
            ST_HMUL0:  state_next = ST_HMUL1;
            ST_HMUL1:  state_next = ST_HEAD;
            ST_HEAD:   state_next = ST_CORDIC;
            ST_CORDIC: if (iter_reg == 5'(Steps - 1)) state_next = ST_DIST;
            ST_DIST:   state_next = ST_PX;
            ST_PX:     state_next = ST_PY;
            ST_PY:     state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // cordic micro-rotation
    logic signed [31:0] sh_x, sh_y, atan_v;
    assign sh_x   = cx_reg >>> iter_reg;
    assign sh_y   = cy_reg >>> iter_reg;
    assign atan_v = $signed(atan_lookup(iter_reg));

    logic [15:0] q_off, red;
    logic [1:0]  q_next;
    assign q_next = 2'((theta_reg + 16'h2000) >> 14);
    assign q_off  = {q_next, 14'd0};
    assign red    = theta_reg - q_off;

    // reduced angle and quadrant once the new heading is in place
    logic cz_load;
    assign cz_load = (state_reg == ST_CORDIC) && (iter_reg == 5'd0);
    logic signed [31:0] z0;
    assign z0 = {red, 16'd0};
    logic signed [31:0] cz_use;
    assign cz_use = cz_load ? z0 : cz_reg;

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg        <= POS_WIDTH'(655360);
            y_reg        <= POS_WIDTH'(655360);
            theta_reg    <= '0;
            lin_reg      <= '0;
            ang_reg      <= '0;
            goal_lin_reg <= '0;
            goal_ang_reg <= '0;
            ticks_reg    <= '0;
            out_full_reg <= 1'b0;
            emerg_reg    <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            if (m_fire) out_full_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_fire) begin
                    logic [15:0] t;
                    t = s_command_valid ? 16'd0 : ticks_reg;
                    if (s_command_valid) begin
                        goal_lin_reg <= s_target_linear;
                        goal_ang_reg <= s_target_angular;
                    end
                    emerg_reg <= t > timeout_reg;
                    ticks_reg <= (t == 16'hFFFF) ? t : t + 16'd1;
                    hit_reg   <= s_collision;
                end
                ST_DLIN: dlin_reg <= mul_p[31:16];
                ST_DANG: dang_reg <= mul_p[31:16];
                ST_SLEW: begin
                    lin_reg <= slew(lin_reg, emerg_reg ? 16'sd0 : goal_lin_reg, dlin_reg);
                    ang_reg <= slew(ang_reg, emerg_reg ? 16'sd0 : goal_ang_reg, dang_reg);
                end
                ST_HMUL0: hmul_reg <= mul_p[31:0];
                ST_HMUL1: prod_reg <= 48'(rnd(mul_p, 44));
                ST_HEAD: begin
                    theta_reg <= theta_reg + prod_reg[15:0];
                end
                ST_CORDIC: begin
                    if (cz_load) quad_reg <= q_next;
                    if (cz_use >= 0) begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                        cz_reg <= cz_use - atan_v;
                    end else begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                        cz_reg <= cz_use + atan_v;
                    end
                    iter_reg <= iter_reg + 5'd1;
                end
                ST_DIST: dist_reg <= mul_p[31:0];
                ST_PX:   x_reg <= padd(x_reg, rnd(mul_p, 42));
                ST_PY:   y_reg <= padd(y_reg, rnd(mul_p, 42));
                ST_DONE: begin
                    out_full_reg           <= 1'b1;
                    m_pos_x                <= 32'(x_reg);
                    m_pos_y                <= 32'(y_reg);
                    m_heading              <= theta_reg;
                    m_vel_linear           <= hit_reg ? 16'sd0 : lin_reg;
                    m_vel_angular          <= hit_reg ? 16'sd0 : ang_reg;
                    m_emergency            <= emerg_reg;
                    m_stopped_by_collision <= hit_reg;
                    if (hit_reg) begin
                        lin_reg <= '0;
                        ang_reg <= '0;
                    end
                end
                default: ;
            endcase
            // cordic setup rides on the heading update cycle
            if (state_reg == ST_HEAD) begin
                iter_reg <= '0;
                cx_reg   <= CordicGain;
                cy_reg   <= '0;
            end
        end
    end

    assign m_valid = out_full_reg;

    // assertions
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pos_x) && $stable(m_heading)))
        else $error("result changed while stalled");
    a_done_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> m_valid)
        else $error("result not posted");
endmodule

// File: test/vrpi_checker.sv
// vrpi_checker: predicts and checks the results of velocity_ramp_pose_integrator
// depends on vrpi_pkg; watches the config port and both channels, counts mismatches
`timescale 1ns / 100ps

module vrpi_checker
    import vrpi_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_command_valid,
    input  logic signed [15:0] s_target_linear,
    input  logic signed [15:0] s_target_angular,
    input  logic               s_collision,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_pos_x,
    input  logic signed [31:0] m_pos_y,
    input  logic [15:0]        m_heading,
    input  logic signed [15:0] m_vel_linear,
    input  logic signed [15:0] m_vel_angular,
    input  logic               m_emergency,
    input  logic               m_stopped_by_collision,
    output int                 outstanding,
    output int                 mismatches
);

    localparam longint ArcTab [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };
    localparam longint PosHome = 64'sd655360;
    localparam longint PosMax  = (64'sd1 <<< (PosWidthDefault - 1)) - 1;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] hd;
        logic [15:0] vl;
        logic [15:0] va;
        logic        em;
        logic        hit;
    } pose_t;

    pose_t pose_q[$];

    // shadow configuration
    int step_q, tmo_q, acc_lin_q, acc_ang_q, dec_lin_q, dec_ang_q;
    // shadow odometry state
    longint      x_acc, y_acc;
    logic [15:0] theta;
    int          lin_v, ang_v, goal_lin, goal_ang;
    int          idle_ticks;

    assign outstanding = pose_q.size();

    // shift right with the half rounded away from zero
    function automatic longint round_shift(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // move toward goal by at most rate*step, no overshoot
    function automatic int ramp(int v, int goal, int rate);
        int d;
        int n;
        d = int'((longint'(rate) * longint'(step_q)) >>> 16);
        if (v < goal) begin
            n = v + d;
            return (n < goal) ? n : goal;
        end
        if (v > goal) begin
            n = v - d;
            return (n > goal) ? n : goal;
        end
        return v;
    endfunction

    // cos/sin of a binary angle, Q2.30
    task automatic rotate(input logic [15:0] ang, output longint c, output longint s);
        int unsigned a;
        int unsigned q;
        longint      z;
        longint      x;
        longint      y;
        longint      nx;
        a = ang;
        q = ((a + 32'h2000) >> 14) & 3;
        z = longint'($signed(16'(a - q * 32'h4000))) * 65536;
        x = longint'(CordicGain);
        y = 0;
        for (int i = 0; i < CordicStepsDefault && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ArcTab[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ArcTab[i];
            end
            x = nx;
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    function automatic longint clamp_pos(longint p, longint d);
        longint n;
        n = p + d;
        if (n > PosMax) return PosMax;
        if (n < -PosMax - 1) return -PosMax - 1;
        return n;
    endfunction

    // advance the odometry by one tick and queue the expected pose
    task automatic advance_tick(input logic cmd, input int tl, input int ta, input logic hit);
        pose_t  e;
        logic   emerg;
        longint c;
        longint s;
        longint travel;
        if (cmd) begin
            goal_lin   = tl;
            goal_ang   = ta;
            idle_ticks = 0;
        end
        emerg = idle_ticks > tmo_q;
        if (idle_ticks < 65535) idle_ticks++;
        lin_v = ramp(lin_v, emerg ? 0 : goal_lin, emerg ? dec_lin_q : acc_lin_q);
        ang_v = ramp(ang_v, emerg ? 0 : goal_ang, emerg ? dec_ang_q : acc_ang_q);
        theta = theta + 16'(round_shift(longint'(ang_v) * longint'(step_q)
                                        * longint'(RadToBam), 44));
        rotate(theta, c, s);
        travel = longint'(lin_v) * longint'(step_q);
        x_acc  = clamp_pos(x_acc, round_shift(travel * c, 42));
        y_acc  = clamp_pos(y_acc, round_shift(travel * s, 42));
        if (hit) begin
            lin_v = 0;
            ang_v = 0;
        end
        e.px  = x_acc[31:0];
        e.py  = y_acc[31:0];
        e.hd  = theta;
        e.vl  = 16'(lin_v);
        e.va  = 16'(ang_v);
        e.em  = emerg;
        e.hit = hit;
        pose_q.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    initial mismatches = 0;

    // sample everything at the rising edge
    always @(posedge aclk) begin
        pose_t e;
        if (!aresetn) begin
            step_q = StepTimeReset;  tmo_q = TimeoutReset;
            acc_lin_q = AccelReset;  acc_ang_q = AccelReset;
            dec_lin_q = DecelReset;  dec_ang_q = DecelReset;
            x_acc = PosHome;  y_acc = PosHome;  theta = '0;
            lin_v = 0;  ang_v = 0;  goal_lin = 0;  goal_ang = 0;
            idle_ticks = 0;
            pose_q.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    RegStepTime: step_q    = cfg_data;
                    RegTimeout:  tmo_q     = cfg_data;
                    RegAccelLin: acc_lin_q = cfg_data[14:0];
                    RegAccelAng: acc_ang_q = cfg_data[14:0];
                    RegDecelLin: dec_lin_q = cfg_data[14:0];
                    RegDecelAng: dec_ang_q = cfg_data[14:0];
                    default: ;
                endcase
            end
            // input transaction
            if (s_valid && s_ready)
                advance_tick(s_command_valid, s_target_linear, s_target_angular, s_collision);
            // result transaction
            if (m_valid && m_ready) begin
                if (pose_q.size() == 0) begin
                    $error("result transaction with no expected pose pending");
                    mismatches++;
                end else begin
                    e = pose_q.pop_front();
                    check_field("pos_x", e.px, m_pos_x);
                    check_field("pos_y", e.py, m_pos_y);
                    check_field("heading", e.hd, m_heading);
                    check_field("vel_linear", e.vl, $unsigned(m_vel_linear));
                    check_field("vel_angular", e.va, $unsigned(m_vel_angular));
                    check_field("emergency", e.em, m_emergency);
                    check_field("stopped_by_collision", e.hit, m_stopped_by_collision);
                end
            end
        end
    end

endmodule

// File: test/velocity_ramp_pose_integrator_tb.sv
// velocity_ramp_pose_integrator_tb: stimulus, idling and verdict for the pose integrator
// depends on vrpi_pkg, velocity_ramp_pose_integrator and vrpi_checker
`timescale 1ns / 100ps

module velocity_ramp_pose_integrator_tb;
    import vrpi_pkg::*;

    localparam int StallLimit = 3000;
    localparam int Drain      = CordicStepsDefault + 14;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_command_valid = 1'b0;
    logic signed [15:0] s_target_linear = '0;
    logic signed [15:0] s_target_angular = '0;
    logic               s_collision = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic [15:0]        m_heading;
    logic signed [15:0] m_vel_linear;
    logic signed [15:0] m_vel_angular;
    logic               m_emergency;
    logic               m_stopped_by_collision;
    int                 outstanding;
    int                 mismatches;
    logic               no_gaps = 1'b0;
    int                 stall_cycles = 0;

    always #6 aclk = ~aclk;

    velocity_ramp_pose_integrator i_dut (.*);

    vrpi_checker i_checker (.*);

    // result side back-pressure
    always @(negedge aclk)
        m_ready <= no_gaps || ($urandom_range(99) >= 24);

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one register write, after which the write enable goes quiet again
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // one tick transaction, with a random gap in front
    task automatic send_tick(input logic cmd, input logic [15:0] tl, input logic [15:0] ta,
                             input logic hit);
        while (!no_gaps && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_command_valid  <= cmd;
        s_target_linear  <= tl;
        s_target_angular <= ta;
        s_collision      <= hit;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // wait until every expected pose has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (Drain) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] v_step;
        logic [15:0] v_tmo;
        int          cmd_pct;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset settings, extreme commands and collisions
        send_tick(1'b1, 16'h7FFF, 16'h8000, 1'b0);
        send_tick(1'b0, 16'h0000, 16'h0000, 1'b0);
        send_tick(1'b1, 16'h8000, 16'h7FFF, 1'b0);
        send_tick(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_tick(1'b1, 16'h0000, 16'h0000, 1'b0);
        send_tick(1'b1, 16'h0001, 16'hFFFF, 1'b1);
        settle();

        // directed: full-scale rates but the smallest linear deceleration, zero timeout so braking starts at once
        write_reg(RegStepTime, 16'hFFFF);
        write_reg(RegTimeout, 16'h0000);
        write_reg(RegAccelLin, 16'hFFFF);
        write_reg(RegAccelAng, 16'h7FFF);
        write_reg(RegDecelLin, 16'h0001);
        write_reg(RegDecelAng, 16'h7FFF);
        send_tick(1'b1, 16'h7FFF, 16'h7FFF, 1'b0);
        repeat (4) send_tick(1'b0, 16'h1234, 16'h4321, 1'b0);
        send_tick(1'b1, 16'h8000, 16'h8000, 1'b0);
        send_tick(1'b0, 16'h0000, 16'h0000, 1'b1);
        send_tick(1'b1, 16'h8000, 16'h7FFF, 1'b0);
        send_tick(1'b1, 16'h7FFF, 16'h8000, 1'b0);
        send_tick(1'b0, 16'h0000, 16'h0000, 1'b0);
        settle();
        // out-of-range indexes are ignored
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h5A5A);

        // random phases, each with its own settings
        for (int p = 0; p < 6; p++) begin
            v_step = (p == 0) ? 16'd1 : (p == 1) ? 16'hFFFF : 16'($urandom_range(65535, 1));
            v_tmo  = (p == 2) ? 16'd0 : (p == 3) ? 16'hFFFF : 16'($urandom_range(30));
            write_reg(RegStepTime, v_step);
            write_reg(RegTimeout, v_tmo);
            write_reg(RegAccelLin, (p == 4) ? 16'h0000 : 16'($urandom));
            write_reg(RegAccelAng, (p == 1) ? 16'h7FFF : 16'($urandom));
            write_reg(RegDecelLin, (p == 5) ? 16'h7FFF : 16'($urandom));
            write_reg(RegDecelAng, (p == 4) ? 16'h0000 : 16'($urandom));
            no_gaps = (p == 3);
            cmd_pct = (p == 3) ? 30 : $urandom_range(25, 3);
            for (int n = 0; n < 190; n++)
                send_tick($urandom_range(99) < cmd_pct, pick_speed(), pick_speed(),
                          $urandom_range(99) < 6);
            settle();
            no_gaps = 1'b0;
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: velocity_ramp_pose_integrator.f
hw/rtl/vrpi_pkg.sv
hw/rtl/velocity_ramp_pose_integrator.sv
test/vrpi_checker.sv
test/velocity_ramp_pose_integrator_tb.sv
